// ===== rtl/rdiu_pkg.sv =====
// Shared types and constants for the run-length index decoder.
`default_nettype none
package rdiu_pkg;

    localparam int BYTE_W    = 8;
    localparam int POS_W     = 14;
    localparam int BPR_W     = 15;
    localparam int ROWS_W    = 15;
    localparam int PEND_W    = 8;
    localparam int APB_AW    = 4;
    localparam int APB_DW    = 32;
    localparam int TUSER_W   = 4;

    localparam logic [BPR_W-1:0]  ROW_LIMIT_MAX = 15'd16384;
    localparam logic [BYTE_W-1:0] HDR_LIT_MAX   = 8'd128;
    localparam logic [BYTE_W-1:0] RUN_BIAS      = 8'd127;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_COMPRESSED    = 2'd0;
    localparam logic [1:0] REG_BYTES_PER_ROW = 2'd1;
    localparam logic [1:0] REG_ROW_COUNT     = 2'd2;

    typedef enum logic [2:0] {
        ST_HEADER,
        ST_LITERAL,
        ST_RUN_WAIT,
        ST_RUN_EMIT,
        ST_STOP
    } t_state;

    typedef struct packed {
        logic emit_byte;   // one decoded byte from the input beat
        logic emit_run;    // one or two copies of the latched run byte
        logic load_hdr;
        logic load_run;
        logic dec_pend;
        logic error;
    } t_cmd;

    typedef struct packed {
        logic hdr_is_run;
        logic pend_one;
        logic run_done;
        logic img_last;
        logic out_free;
    } t_sts;

    typedef struct packed {
        logic [BYTE_W-1:0] first_index_byte;
        logic [BYTE_W-1:0] second_index_byte;
        logic              second_valid;
        logic              row_end_first;
        logic              row_end_second;
        logic              image_done;
        logic              decode_error;
    } t_result;

endpackage
`default_nettype wire

// ===== rtl/rdiu_cfg.sv =====
// APB configuration registers of the run-length index decoder.
`default_nettype none
module rdiu_cfg import rdiu_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_psel,
    input  wire logic              i_penable,
    input  wire logic              i_pwrite,
    input  wire logic [APB_AW-1:0] i_paddr,
    input  wire logic [APB_DW-1:0] i_pwdata,
    output logic      [APB_DW-1:0] o_prdata,
    output logic                   o_pready,
    output logic                   o_compressed,
    output logic      [BPR_W-1:0]  o_bytes_per_row,
    output logic      [ROWS_W-1:0] o_row_count
);

    logic              r_compressed;
    logic [BPR_W-1:0]  r_bytes_per_row;
    logic [ROWS_W-1:0] r_row_count;
    logic              w_wr;
    logic [1:0]        w_idx;

    assign o_pready = 1'b1;
    assign w_wr     = i_psel & i_penable & i_pwrite;
    assign w_idx    = i_paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_compressed    <= 1'b1;
            r_bytes_per_row <= BPR_W'(1);
            r_row_count     <= ROWS_W'(1);
        end else if (w_wr) begin
            case (w_idx)
                REG_COMPRESSED:    r_compressed    <= i_pwdata[0];
                REG_BYTES_PER_ROW: r_bytes_per_row <= i_pwdata[BPR_W-1:0];
                REG_ROW_COUNT:     r_row_count     <= i_pwdata[ROWS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        o_prdata = '0;
        case (w_idx)
            REG_COMPRESSED:    o_prdata = APB_DW'(r_compressed);
            REG_BYTES_PER_ROW: o_prdata = APB_DW'(r_bytes_per_row);
            REG_ROW_COUNT:     o_prdata = APB_DW'(r_row_count);
            default:           o_prdata = '0;
        endcase
    end

    assign o_compressed    = r_compressed;
    assign o_bytes_per_row = r_bytes_per_row;
    assign o_row_count     = r_row_count;

endmodule
`default_nettype wire

// ===== rtl/rdiu_ctrl.sv =====
// Decode controller: header/literal/run sequencing and input handshake.
`default_nettype none
module rdiu_ctrl import rdiu_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_tvalid,
    input  wire logic i_end_of_stream,
    input  wire logic i_compressed,
    input  wire t_sts i_sts,
    output logic      o_in_tready,
    output t_cmd      o_cmd,
    output t_state    o_state
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HEADER;
        end else begin
            r_state <= n_state;
        end
    end

    // command decode
    always_comb begin
        o_cmd       = '0;
        o_in_tready = 1'b0;
        case (r_state)
            ST_STOP: begin
                o_in_tready = 1'b1;   // beats are swallowed until reset
            end
            ST_RUN_EMIT: begin
                o_cmd.emit_run = i_sts.out_free;
            end
            default: begin
                o_in_tready = i_sts.out_free;
                if (i_in_tvalid && i_sts.out_free) begin
                    if (i_end_of_stream) begin
                        o_cmd.error = 1'b1;
                    end else if (!i_compressed) begin
                        o_cmd.emit_byte = 1'b1;
                    end else begin
                        case (r_state)
                            ST_HEADER: begin
                                o_cmd.load_hdr = 1'b1;
                            end
                            ST_LITERAL: begin
                                o_cmd.emit_byte = 1'b1;
                                o_cmd.dec_pend  = 1'b1;
                            end
                            ST_RUN_WAIT: begin
                                o_cmd.load_run = 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_STOP: n_state = ST_STOP;
            ST_RUN_EMIT: begin
                if (o_cmd.emit_run) begin
                    if (i_sts.img_last) begin
                        n_state = ST_STOP;
                    end else if (i_sts.run_done) begin
                        n_state = ST_HEADER;
                    end
                end
            end
            default: begin
                if (o_cmd.error) begin
                    n_state = ST_STOP;
                end else if (o_cmd.emit_byte && i_sts.img_last) begin
                    n_state = ST_STOP;
                end else if (o_cmd.load_hdr) begin
                    n_state = i_sts.hdr_is_run ? ST_RUN_WAIT : ST_LITERAL;
                end else if (o_cmd.dec_pend && i_sts.pend_one) begin
                    n_state = ST_HEADER;
                end else if (o_cmd.load_run) begin
                    n_state = ST_RUN_EMIT;
                end
            end
        endcase
    end

    assign o_state = r_state;

endmodule
`default_nettype wire

// ===== rtl/rdiu_dp.sv =====
// Decode datapath: run count, row/image position, result register.
`default_nettype none
module rdiu_dp import rdiu_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd              i_cmd,
    input  wire logic [BYTE_W-1:0] i_data_byte,
    input  wire logic [BPR_W-1:0]  i_bytes_per_row,
    input  wire logic [ROWS_W-1:0] i_row_count,
    input  wire logic              i_out_tready,
    output t_sts                   o_sts,
    output logic                   o_out_tvalid,
    output t_result                o_result
);

    logic [PEND_W-1:0] r_pend;
    logic [PEND_W-1:0] n_pend;
    logic [BYTE_W-1:0] r_run_byte;
    logic [POS_W-1:0]  r_byte_in_row;
    logic [POS_W-1:0]  n_byte_in_row;
    logic [ROWS_W-1:0] r_row_index;
    logic [ROWS_W-1:0] n_row_index;
    logic              r_out_valid;
    t_result           r_result;
    t_result           n_result;

    logic [BPR_W-1:0]  w_row_lim;
    logic [ROWS_W-1:0] w_rows;
    logic [BPR_W-1:0]  w_pos_inc1, w_pos_inc2;
    logic [ROWS_W:0]   w_row_inc1, w_row_inc2;
    logic              w_re1, w_re2, w_last1, w_last2;
    logic [POS_W-1:0]  w_bir1, w_bir2;
    logic [ROWS_W-1:0] w_row1, w_row2;
    logic              w_two;
    logic              w_emit;
    logic [BYTE_W-1:0] w_src;

    // out-of-range limits clamp
    always_comb begin
        if (i_bytes_per_row == '0) begin
            w_row_lim = BPR_W'(1);
        end else if (i_bytes_per_row > ROW_LIMIT_MAX) begin
            w_row_lim = ROW_LIMIT_MAX;
        end else begin
            w_row_lim = i_bytes_per_row;
        end
        w_rows = (i_row_count == '0) ? ROWS_W'(1) : i_row_count;
    end

    // position after the first byte
    always_comb begin
        w_pos_inc1 = {1'b0, r_byte_in_row} + BPR_W'(1);
        w_row_inc1 = {1'b0, r_row_index} + (ROWS_W+1)'(1);
        w_re1      = w_pos_inc1 >= w_row_lim;
        w_last1    = w_re1 && (w_row_inc1 >= {1'b0, w_rows});
        w_bir1     = w_re1 ? '0 : w_pos_inc1[POS_W-1:0];
        if (w_re1) begin
            w_row1 = w_last1 ? '0 : w_row_inc1[ROWS_W-1:0];
        end else begin
            w_row1 = r_row_index;
        end
    end

    // position after the second byte of a pair
    always_comb begin
        w_pos_inc2 = {1'b0, w_bir1} + BPR_W'(1);
        w_row_inc2 = {1'b0, w_row1} + (ROWS_W+1)'(1);
        w_re2      = w_pos_inc2 >= w_row_lim;
        w_last2    = w_re2 && (w_row_inc2 >= {1'b0, w_rows});
        w_bir2     = w_re2 ? '0 : w_pos_inc2[POS_W-1:0];
        if (w_re2) begin
            w_row2 = w_last2 ? '0 : w_row_inc2[ROWS_W-1:0];
        end else begin
            w_row2 = w_row1;
        end
    end

    // a pair only while the run holds two more and the image is not ended
    assign w_two  = i_cmd.emit_run && (r_pend >= PEND_W'(2)) && !w_last1;
    assign w_emit = i_cmd.emit_byte | i_cmd.emit_run;
    assign w_src  = i_cmd.emit_run ? r_run_byte : i_data_byte;

    always_comb begin
        n_pend = r_pend;
        if (i_cmd.load_hdr) begin
            if (i_data_byte > HDR_LIT_MAX) begin
                n_pend = i_data_byte - RUN_BIAS;
            end else begin
                n_pend = i_data_byte + PEND_W'(1);
            end
        end else if (i_cmd.dec_pend) begin
            n_pend = r_pend - PEND_W'(1);
        end else if (i_cmd.emit_run) begin
            n_pend = r_pend - (w_two ? PEND_W'(2) : PEND_W'(1));
        end
    end

    always_comb begin
        n_byte_in_row = r_byte_in_row;
        n_row_index   = r_row_index;
        if (w_emit) begin
            n_byte_in_row = w_two ? w_bir2 : w_bir1;
            n_row_index   = w_two ? w_row2 : w_row1;
        end
    end

    always_comb begin
        n_result = '0;
        if (i_cmd.error) begin
            n_result.decode_error = 1'b1;
        end else begin
            n_result.first_index_byte  = ~w_src;
            n_result.second_index_byte = w_two ? ~w_src : '0;
            n_result.second_valid      = w_two;
            n_result.row_end_first     = w_re1;
            n_result.row_end_second    = w_two & w_re2;
            n_result.image_done        = w_last1 | (w_two & w_last2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend        <= '0;
            r_byte_in_row <= '0;
            r_row_index   <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_pend        <= n_pend;
            r_byte_in_row <= n_byte_in_row;
            r_row_index   <= n_row_index;
            if (w_emit || i_cmd.error) begin
                r_out_valid <= 1'b1;
            end else if (i_out_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_run) begin
            r_run_byte <= i_data_byte;
        end
        if (w_emit || i_cmd.error) begin
            r_result <= n_result;
        end
    end

    always_comb begin
        o_sts            = '0;
        o_sts.hdr_is_run = i_data_byte > HDR_LIT_MAX;
        o_sts.pend_one   = r_pend == PEND_W'(1);
        o_sts.run_done   = r_pend <= PEND_W'(2);
        o_sts.img_last   = w_last1 | (w_two & w_last2);
        o_sts.out_free   = !r_out_valid || i_out_tready;
    end

    assign o_out_tvalid = r_out_valid;
    assign o_result     = r_result;

endmodule
`default_nettype wire

// ===== rtl/rle_decode_index_unpack.sv =====
// A literal or raw byte appears on the output register in the cycle after its beat.
// A header beat gives no output; a run value beat is followed by ceil(n/2) output beats,
// one per cycle while the sink is ready, input held off meanwhile. Throughput while the
// sink is ready: 1 input beat per cycle for headers, literals and raw bytes, set by the
// single result register; runs are paced by the pair emitter (2 bytes per cycle).
// Reset (synchronous, active low): decoder awaits a header, counters zero, regs 1/1/1.
`default_nettype none
module rle_decode_index_unpack import rdiu_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // slave stream
    input  wire logic               i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    input  wire logic [BYTE_W-1:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  wire logic               i_s_axis_tlast,   // end_of_stream
    // master stream
    output logic                    o_m_axis_tvalid,
    input  wire logic               i_m_axis_tready,
    output logic [2*BYTE_W-1:0]     o_m_axis_tdata,   // [7:0] first_index_byte,
                                                      // [15:8] second_index_byte
    output logic [TUSER_W-1:0]      o_m_axis_tuser,   // [0] second_valid, [1] row_end_first,
                                                      // [2] row_end_second, [3] decode_error
    output logic                    o_m_axis_tlast,   // image_done
    // APB configuration
    input  wire logic               i_psel,
    input  wire logic               i_penable,
    input  wire logic               i_pwrite,
    input  wire logic [APB_AW-1:0]  i_paddr,
    input  wire logic [APB_DW-1:0]  i_pwdata,
    output logic      [APB_DW-1:0]  o_prdata,
    output logic                    o_pready
);

    logic              w_compressed;
    logic [BPR_W-1:0]  w_bytes_per_row;
    logic [ROWS_W-1:0] w_row_count;
    t_cmd              w_cmd;
    t_sts              w_sts;
    t_state            w_state;
    t_result           w_result;

    rdiu_cfg u_cfg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_psel          (i_psel),
        .i_penable       (i_penable),
        .i_pwrite        (i_pwrite),
        .i_paddr         (i_paddr),
        .i_pwdata        (i_pwdata),
        .o_prdata        (o_prdata),
        .o_pready        (o_pready),
        .o_compressed    (w_compressed),
        .o_bytes_per_row (w_bytes_per_row),
        .o_row_count     (w_row_count)
    );

    rdiu_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_tvalid     (i_s_axis_tvalid),
        .i_end_of_stream (i_s_axis_tlast),
        .i_compressed    (w_compressed),
        .i_sts           (w_sts),
        .o_in_tready     (o_s_axis_tready),
        .o_cmd           (w_cmd),
        .o_state         (w_state)
    );

    rdiu_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_data_byte     (i_s_axis_tdata),
        .i_bytes_per_row (w_bytes_per_row),
        .i_row_count     (w_row_count),
        .i_out_tready    (i_m_axis_tready),
        .o_sts           (w_sts),
        .o_out_tvalid    (o_m_axis_tvalid),
        .o_result        (w_result)
    );

    assign o_m_axis_tdata = {w_result.second_index_byte, w_result.first_index_byte};
    assign o_m_axis_tuser = {w_result.decode_error, w_result.row_end_second,
                             w_result.row_end_first, w_result.second_valid};
    assign o_m_axis_tlast = w_result.image_done;

    // input is held off while a run is being expanded
    a_run_stalls_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_state == ST_RUN_EMIT) |-> !o_s_axis_tready)
        else $error("input ready during run expansion");

    // an error beat carries nothing else
    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[3]) |->
            (o_m_axis_tdata == '0 && o_m_axis_tuser[2:0] == '0 && !o_m_axis_tlast))
        else $error("error beat with payload");

    // an image-end or error beat only ever exists once the decoder has stopped
    a_done_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tlast || o_m_axis_tuser[3])) |-> (w_state == ST_STOP))
        else $error("image end or error without stop");

    // a single-byte beat leaves the second slot empty
    a_single_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser[0]) |->
            (o_m_axis_tdata[2*BYTE_W-1:BYTE_W] == '0 && !o_m_axis_tuser[2]))
        else $error("second byte set without second_valid");

endmodule
`default_nettype wire
